FILE: rtl/json_string_unescape_utf8_defines.svh
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms for the unescaper modules.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Checked at every clock edge outside reset.
`define JSU_ASSERT_PROP(lbl, clk_, rst_, prop, msg) \
  lbl: assert property (@(posedge clk_) disable iff (rst_) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, clk_, prop, msg) \
  lbl: assert property (@(posedge clk_) prop) else $error(msg);

`endif

FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Types, character codes, status codes and decode functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int CAP_W = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF8_MASK6 = 8'h3F;

  typedef enum logic [2:0] {
    MODE_WAIT,
    MODE_STR,
    MODE_ESC,
    MODE_HEX,
    MODE_HIGH1,
    MODE_HIGH2,
    MODE_LOWHEX,
    MODE_IDLE
  } mode_t;

  typedef enum logic [3:0] {
    ST_NONE = 4'd0,
    ST_OK = 4'd1,
    ST_EXPECTED_STRING = 4'd2,
    ST_BAD_ESCAPE = 4'd3,
    ST_BAD_UNICODE = 4'd4,
    ST_TRUNC_UNICODE = 4'd5,
    ST_TRUNC_PAIR = 4'd6,
    ST_BAD_PAIR = 4'd7,
    ST_UNTERMINATED = 4'd8
  } status_t;

  typedef struct packed {
    logic [7:0] value;
    logic eot;
    logic restart;
  } jsu_item_t;

  typedef struct packed {
    mode_t mode;
    logic [15:0] acc;
    logic [2:0] seen;
    logic bad;
    logic [15:0] pend;
  } jsu_state_t;

  localparam jsu_state_t STATE_CLEAR = '{
    mode: MODE_WAIT, acc: 16'h0, seen: 3'd0, bad: 1'b0, pend: 16'h0
  };

  typedef struct packed {
    logic [7:0] value;
    logic is_data;
    status_t status;
  } jsu_result_t;

  typedef struct packed {
    jsu_result_t [MAX_RESULTS-1:0] item;
    logic [2:0] n;
  } jsu_batch_t;

  typedef struct packed {
    logic ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic ok;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] b;
    logic [2:0] n;
  } utf8_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    logic [7:0] t;
    r = '0;
    t = 8'h0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      r.ok = 1'b1;
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      t = c - CH_LOW_A + 8'd10;
      r.ok = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      t = c - CH_UP_A + 8'd10;
      r.ok = 1'b1;
    end
    r.val = t[3:0];
    return r;
  endfunction

  function automatic esc_t esc_decode(input logic [7:0] c);
    esc_t r;
    r.ok = 1'b1;
    r.val = c;
    case (c) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: r.val = c;
      CH_LOW_B: r.val = CH_BS;
      CH_LOW_F: r.val = CH_FF;
      CH_LOW_N: r.val = CH_LF;
      CH_LOW_R: r.val = CH_CR;
      CH_LOW_T: r.val = CH_TAB;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    r.n = 3'd1;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.b[1] = UTF8_CONT | (UTF8_MASK6 & {2'b00, cp[5:0]});
      r.n = 3'd2;
    end else if (cp < SUPP_BASE) begin
      r.b[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
      r.b[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.b[2] = UTF8_CONT | {2'b00, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.b[0] = UTF8_LEAD4 | {5'h00, cp[20:18]};
      r.b[1] = UTF8_CONT | {2'b00, cp[17:12]};
      r.b[2] = UTF8_CONT | {2'b00, cp[11:6]};
      r.b[3] = UTF8_CONT | {2'b00, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

endpackage

FILE: rtl/jsu_step.sv
// ----------------------------------------------------------------------------
// JSON string unescaper step logic
// Decodes one registered text byte against the parse state into a batch of
// up to four results and the next parse state.
// ----------------------------------------------------------------------------
module jsu_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  jsu_pkg::jsu_item_t          item,
  input  jsu_pkg::jsu_state_t         state,
  input  logic [COUNT_WIDTH-1:0]      count,
  input  logic [jsu_pkg::CAP_W-1:0]   capacity,
  output jsu_pkg::jsu_state_t         state_next,
  output logic [COUNT_WIDTH-1:0]      count_next,
  output jsu_pkg::jsu_batch_t         batch
);

  localparam int CMP_W = ((COUNT_WIDTH > jsu_pkg::CAP_W) ? COUNT_WIDTH : jsu_pkg::CAP_W) + 1;

  jsu_pkg::jsu_state_t eff;
  logic [COUNT_WIDTH-1:0] eff_count;

  jsu_pkg::utf8_t enc_pend;
  logic [COUNT_WIDTH:0] pend_sum;
  logic [COUNT_WIDTH-1:0] count_pend;
  logic room_now;
  logic room_pend;
  logic room_str;

  jsu_pkg::hex_t hx;
  jsu_pkg::esc_t esc;
  logic [15:0] acc_n;
  logic [2:0] seen_n;
  logic bad_n;
  logic is_low;
  logic is_blank;
  logic [20:0] pair_cp;

  logic cp_en;
  logic [20:0] cp_val;
  logic tail_en;
  logic tail_data;
  logic [7:0] tail_value;
  jsu_pkg::status_t tail_status;

  jsu_pkg::utf8_t enc;
  logic [2:0] n_cp;
  logic [2:0] n_data;
  logic [COUNT_WIDTH:0] count_sum;
  jsu_pkg::jsu_result_t tail;

  always_comb begin
    eff = state;
    eff_count = count;
    if (item.restart) begin
      eff = jsu_pkg::STATE_CLEAR;
      eff_count = '0;
    end
  end

  assign enc_pend = jsu_pkg::utf8_encode({5'b0, eff.pend});
  assign pend_sum = {1'b0, eff_count} + (COUNT_WIDTH+1)'(enc_pend.n);
  assign count_pend = pend_sum[COUNT_WIDTH] ? '1 : pend_sum[COUNT_WIDTH-1:0];
  assign room_now = (CMP_W'(eff_count) + CMP_W'(4)) < CMP_W'(capacity);
  assign room_pend = (CMP_W'(count_pend) + CMP_W'(4)) < CMP_W'(capacity);
  assign room_str = (eff.mode == jsu_pkg::MODE_HIGH1) ? room_pend : room_now;

  assign hx = jsu_pkg::hex_decode(item.value);
  assign esc = jsu_pkg::esc_decode(item.value);
  assign acc_n = {eff.acc[11:0], (hx.ok ? hx.val : 4'h0)};
  assign seen_n = eff.seen + 3'd1;
  assign bad_n = eff.bad | ~hx.ok;
  assign is_low = (eff.mode == jsu_pkg::MODE_LOWHEX);
  assign is_blank = (item.value == jsu_pkg::CH_SPACE) || (item.value == jsu_pkg::CH_TAB) ||
                    (item.value == jsu_pkg::CH_LF) || (item.value == jsu_pkg::CH_CR);
  assign pair_cp = jsu_pkg::SUPP_BASE + {1'b0, eff.pend[9:0], acc_n[9:0]};

  always_comb begin
    state_next = eff;
    cp_en = 1'b0;
    cp_val = {5'b0, eff.pend};
    tail_en = 1'b0;
    tail_data = 1'b0;
    tail_value = 8'h00;
    tail_status = jsu_pkg::ST_NONE;
    unique case (eff.mode) inside
      jsu_pkg::MODE_WAIT: begin
        if (!item.eot && is_blank) begin
          state_next.mode = jsu_pkg::MODE_WAIT;
        end else if (!item.eot && item.value == jsu_pkg::CH_QUOTE) begin
          state_next.mode = jsu_pkg::MODE_STR;
        end else begin
          tail_en = 1'b1;
          tail_status = jsu_pkg::ST_EXPECTED_STRING;
          state_next.mode = jsu_pkg::MODE_IDLE;
        end
      end
      jsu_pkg::MODE_STR, jsu_pkg::MODE_HIGH1: begin
        if (eff.mode == jsu_pkg::MODE_HIGH1 && !item.eot &&
            item.value == jsu_pkg::CH_BSLASH) begin
          state_next.mode = jsu_pkg::MODE_HIGH2;
        end else begin
          cp_en = (eff.mode == jsu_pkg::MODE_HIGH1);
          state_next.mode = jsu_pkg::MODE_STR;
          if (item.eot || (item.value != jsu_pkg::CH_QUOTE && !room_str)) begin
            tail_en = 1'b1;
            tail_status = jsu_pkg::ST_UNTERMINATED;
            state_next.mode = jsu_pkg::MODE_IDLE;
          end else if (item.value == jsu_pkg::CH_QUOTE) begin
            tail_en = 1'b1;
            tail_status = jsu_pkg::ST_OK;
            state_next.mode = jsu_pkg::MODE_IDLE;
          end else if (item.value == jsu_pkg::CH_BSLASH) begin
            state_next.mode = jsu_pkg::MODE_ESC;
          end else begin
            tail_en = 1'b1;
            tail_data = 1'b1;
            tail_value = item.value;
          end
        end
      end
      jsu_pkg::MODE_ESC, jsu_pkg::MODE_HIGH2: begin
        if (!item.eot && item.value == jsu_pkg::CH_LOW_U) begin
          state_next.mode = (eff.mode == jsu_pkg::MODE_HIGH2) ? jsu_pkg::MODE_LOWHEX
                                                              : jsu_pkg::MODE_HEX;
          state_next.acc = 16'h0;
          state_next.seen = 3'd0;
          state_next.bad = 1'b0;
        end else begin
          cp_en = (eff.mode == jsu_pkg::MODE_HIGH2);
          if (eff.mode == jsu_pkg::MODE_HIGH2 && !room_pend) begin
            tail_en = 1'b1;
            tail_status = jsu_pkg::ST_UNTERMINATED;
            state_next.mode = jsu_pkg::MODE_IDLE;
          end else if (item.eot || !esc.ok) begin
            tail_en = 1'b1;
            tail_status = jsu_pkg::ST_BAD_ESCAPE;
            state_next.mode = jsu_pkg::MODE_IDLE;
          end else begin
            tail_en = 1'b1;
            tail_data = 1'b1;
            tail_value = esc.val;
            state_next.mode = jsu_pkg::MODE_STR;
          end
        end
      end
      jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOWHEX: begin
        if (item.eot) begin
          tail_en = 1'b1;
          tail_status = is_low ? jsu_pkg::ST_TRUNC_PAIR : jsu_pkg::ST_TRUNC_UNICODE;
          state_next.mode = jsu_pkg::MODE_IDLE;
        end else begin
          state_next.acc = acc_n;
          state_next.seen = seen_n;
          state_next.bad = bad_n;
          if (seen_n >= jsu_pkg::HEX_DIGITS) begin
            if (bad_n) begin
              tail_en = 1'b1;
              tail_status = is_low ? jsu_pkg::ST_BAD_PAIR : jsu_pkg::ST_BAD_UNICODE;
              state_next.mode = jsu_pkg::MODE_IDLE;
            end else if (!is_low) begin
              if (acc_n >= jsu_pkg::HIGH_SURR_MIN && acc_n <= jsu_pkg::HIGH_SURR_MAX) begin
                state_next.pend = acc_n;
                state_next.mode = jsu_pkg::MODE_HIGH1;
              end else begin
                cp_en = 1'b1;
                cp_val = {5'b0, acc_n};
                state_next.mode = jsu_pkg::MODE_STR;
              end
            end else begin
              cp_en = 1'b1;
              state_next.mode = jsu_pkg::MODE_STR;
              if (acc_n >= jsu_pkg::LOW_SURR_MIN && acc_n <= jsu_pkg::LOW_SURR_MAX &&
                  eff.pend >= jsu_pkg::HIGH_SURR_MIN) begin
                cp_val = pair_cp;
              end
            end
          end
        end
      end
      jsu_pkg::MODE_IDLE: begin
        state_next.mode = jsu_pkg::MODE_IDLE;
      end
    endcase
  end

  assign enc = jsu_pkg::utf8_encode(cp_val);
  assign n_cp = cp_en ? enc.n : 3'd0;
  assign n_data = n_cp + {2'b00, tail_en & tail_data};
  assign count_sum = {1'b0, eff_count} + (COUNT_WIDTH+1)'(n_data);
  assign count_next = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
  assign tail = '{value: tail_value, is_data: tail_data, status: tail_status};

  always_comb begin
    for (int i = 0; i < jsu_pkg::MAX_RESULTS; i++) begin
      if (3'(i) < n_cp) begin
        batch.item[i] = '{value: enc.b[i], is_data: 1'b1, status: jsu_pkg::ST_NONE};
      end else begin
        batch.item[i] = tail;
      end
    end
    batch.n = n_cp + {2'b00, tail_en};
  end

endmodule

FILE: rtl/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// JSON string unescaper result register
// Holds the results of one decoded byte and presents them one per
// transaction on the output stream.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module jsu_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  jsu_pkg::jsu_batch_t batch,
  output logic                free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // out_byte
  output logic [4:0]          m_axis_tuser,  // is_data, status[3:0]
  output logic                m_axis_tlast   // last
);

  jsu_pkg::jsu_batch_t held;
  logic valid;
  logic [1:0] idx;
  logic at_last;
  jsu_pkg::jsu_result_t cur;

  assign cur = held.item[idx];
  assign at_last = ({1'b0, idx} == (held.n - 3'd1));
  assign free = !valid || (m_axis_tready && at_last);

  assign m_axis_tvalid = valid;
  assign m_axis_tdata = cur.value;
  assign m_axis_tuser = {cur.status, cur.is_data};
  assign m_axis_tlast = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx <= 2'd0;
    end else if (valid && m_axis_tready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= batch;
    end
  end

  `JSU_ASSERT_PROP(a_load_when_free, clk, rst, load |-> free, "result register overwritten")
  `JSU_ASSERT_PROP(a_count_range, clk, rst, valid |-> (held.n != 3'd0 && held.n <= 3'd4),
                   "bad result count")
  `JSU_ASSERT_PROP(a_drain_ends, clk, rst,
                   (valid && m_axis_tready && at_last && !load) |=> !valid,
                   "result register did not empty")
  `JSU_ASSERT_PROP(a_status_clean, clk, rst,
                   (valid && !cur.is_data) |->
                   (cur.value == 8'h00 && cur.status != jsu_pkg::ST_NONE),
                   "malformed status result")
  `JSU_ASSERT_PROP(a_data_clean, clk, rst,
                   (valid && cur.is_data) |-> (cur.status == jsu_pkg::ST_NONE),
                   "data result carries a status")

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// A byte accepted into the input register is decoded combinationally and, if it gives any
// result, loaded into the result register once that register is free; its first result is offered from then on.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// is ready; a byte giving more holds the input until the output port has taken them all.
// Reset (rst, synchronous, active high) clears the parse state, the output count and the
// valid flags of both registers, and sets the output capacity to 256.
// ----------------------------------------------------------------------------
// JSON string unescaper
// Streams a JSON string token byte by byte and emits its decoded UTF-8 bytes
// followed by a final status.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [jsu_pkg::CAP_W-1:0] cfg_wdata,      // output_capacity
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // in_byte
  input  logic [1:0]                s_axis_tuser,   // end_of_text, restart
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // out_byte
  output logic [4:0]                m_axis_tuser,   // is_data, status[3:0]
  output logic                      m_axis_tlast    // last
);

  logic [jsu_pkg::CAP_W-1:0] capacity;
  logic in_valid;
  jsu_pkg::jsu_item_t item;
  jsu_pkg::jsu_state_t state;
  jsu_pkg::jsu_state_t state_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  jsu_pkg::jsu_batch_t batch;
  logic free;
  logic process;
  logic load;

  assign process = in_valid && free;
  assign load = process && (batch.n != 3'd0);
  assign s_axis_tready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= jsu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= '{value: s_axis_tdata, eot: s_axis_tuser[0], restart: s_axis_tuser[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsu_pkg::STATE_CLEAR;
      count <= '0;
    end else if (process) begin
      state <= state_next;
      count <= count_next;
    end
  end

  jsu_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .item       (item),
    .state      (state),
    .count      (count),
    .capacity   (capacity),
    .state_next (state_next),
    .count_next (count_next),
    .batch      (batch)
  );

  jsu_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .batch         (batch),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// JSON string unescaper testbench
// Streams JSON string tokens into the unescaper under random valid and ready
// gaps, predicts every decoded byte and final status in a scoreboard, and
// checks each output transaction against the oldest prediction. The output
// capacity is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 45;

  typedef struct packed {
    logic [7:0] octet;
    logic is_data;
    jsu_pkg::status_t st;
    logic last;
  } decoded_t;

  class utf8_scoreboard;
    logic [15:0] capacity;
    jsu_pkg::mode_t mode;
    logic [15:0] written;
    logic [15:0] acc;
    logic [2:0] digits;
    logic digit_bad;
    logic [15:0] high_pending;
    decoded_t due[$];
    decoded_t step_out[$];
    int errors;

    function new();
      capacity = jsu_pkg::CAP_RESET;
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      mode = jsu_pkg::MODE_WAIT;
      written = '0;
      acc = '0;
      digits = '0;
      digit_bad = 1'b0;
      high_pending = '0;
    endfunction

    static function bit nibble_of(input logic [7:0] c, output logic [3:0] d);
      d = 4'h0;
      if (c >= jsu_pkg::CH_ZERO && c <= jsu_pkg::CH_NINE)
        d = 4'(c - jsu_pkg::CH_ZERO);
      else if (c >= jsu_pkg::CH_LOW_A && c <= jsu_pkg::CH_LOW_F)
        d = 4'(c - jsu_pkg::CH_LOW_A + 8'd10);
      else if (c >= jsu_pkg::CH_UP_A && c <= jsu_pkg::CH_UP_F)
        d = 4'(c - jsu_pkg::CH_UP_A + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void push_byte(logic [7:0] b);
      if (written != 16'hFFFF) written++;
      if (step_out.size() < jsu_pkg::MAX_RESULTS)
        step_out.push_back('{b, 1'b1, jsu_pkg::ST_NONE, 1'b0});
    endfunction

    function void push_status(jsu_pkg::status_t s);
      if (step_out.size() < jsu_pkg::MAX_RESULTS) step_out.push_back('{8'h00, 1'b0, s, 1'b0});
      mode = jsu_pkg::MODE_IDLE;
    endfunction

    function bit room();
      return (32'(written) + 32'd4) < 32'(capacity);
    endfunction

    function void push_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        push_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        push_byte(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]});
        push_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end else if (cp < jsu_pkg::SUPP_BASE) begin
        push_byte(jsu_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]});
        push_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]});
        push_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
        push_byte(jsu_pkg::UTF8_LEAD4 | {5'h00, cp[20:18]});
        push_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[17:12]});
        push_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]});
        push_byte(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end
    endfunction

    function void start_hex(jsu_pkg::mode_t m);
      mode = m;
      acc = '0;
      digits = '0;
      digit_bad = 1'b0;
    endfunction

    function void string_char(bit eot, logic [7:0] c);
      if (eot) push_status(jsu_pkg::ST_UNTERMINATED);
      else if (c == jsu_pkg::CH_QUOTE) push_status(jsu_pkg::ST_OK);
      else if (!room()) push_status(jsu_pkg::ST_UNTERMINATED);
      else if (c == jsu_pkg::CH_BSLASH) mode = jsu_pkg::MODE_ESC;
      else push_byte(c);
    endfunction

    function void escape_char(bit eot, logic [7:0] c);
      logic [7:0] b;
      if (eot) begin
        push_status(jsu_pkg::ST_BAD_ESCAPE);
        return;
      end
      case (c)
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: b = c;
        jsu_pkg::CH_LOW_B: b = jsu_pkg::CH_BS;
        jsu_pkg::CH_LOW_F: b = jsu_pkg::CH_FF;
        jsu_pkg::CH_LOW_N: b = jsu_pkg::CH_LF;
        jsu_pkg::CH_LOW_R: b = jsu_pkg::CH_CR;
        jsu_pkg::CH_LOW_T: b = jsu_pkg::CH_TAB;
        jsu_pkg::CH_LOW_U: begin
          start_hex(jsu_pkg::MODE_HEX);
          return;
        end
        default: begin
          push_status(jsu_pkg::ST_BAD_ESCAPE);
          return;
        end
      endcase
      push_byte(b);
      mode = jsu_pkg::MODE_STR;
    endfunction

    function void hex_char(bit eot, logic [7:0] c, bit low);
      logic [3:0] d;
      logic [15:0] v;
      logic [31:0] pair;
      if (eot) begin
        push_status(low ? jsu_pkg::ST_TRUNC_PAIR : jsu_pkg::ST_TRUNC_UNICODE);
        return;
      end
      if (!nibble_of(c, d)) digit_bad = 1'b1;
      acc = {acc[11:0], d};
      digits = digits + 3'd1;
      if (digits < jsu_pkg::HEX_DIGITS) return;
      if (digit_bad) begin
        push_status(low ? jsu_pkg::ST_BAD_PAIR : jsu_pkg::ST_BAD_UNICODE);
        return;
      end
      v = acc;
      mode = jsu_pkg::MODE_STR;
      if (!low) begin
        if (v >= jsu_pkg::HIGH_SURR_MIN && v <= jsu_pkg::HIGH_SURR_MAX) begin
          high_pending = v;
          mode = jsu_pkg::MODE_HIGH1;
        end else begin
          push_code_point({5'b0, v});
        end
      end else if (v >= jsu_pkg::LOW_SURR_MIN && v <= jsu_pkg::LOW_SURR_MAX &&
                   high_pending >= jsu_pkg::HIGH_SURR_MIN) begin
        pair = 32'(jsu_pkg::SUPP_BASE)
               + ((32'(high_pending) - 32'(jsu_pkg::HIGH_SURR_MIN)) << 10)
               + (32'(v) - 32'(jsu_pkg::LOW_SURR_MIN));
        push_code_point(pair[20:0]);
      end else begin
        push_code_point({5'b0, high_pending});
      end
    endfunction

    function void note_byte(logic [7:0] c, bit eot, bit rs);
      bit blank;
      step_out.delete();
      if (rs) clear_token();
      case (mode)
        jsu_pkg::MODE_WAIT: begin
          blank = !eot && (c == jsu_pkg::CH_SPACE || c == jsu_pkg::CH_TAB ||
                           c == jsu_pkg::CH_LF || c == jsu_pkg::CH_CR);
          if (!blank) begin
            if (!eot && c == jsu_pkg::CH_QUOTE) mode = jsu_pkg::MODE_STR;
            else push_status(jsu_pkg::ST_EXPECTED_STRING);
          end
        end
        jsu_pkg::MODE_STR: string_char(eot, c);
        jsu_pkg::MODE_ESC: escape_char(eot, c);
        jsu_pkg::MODE_HEX: hex_char(eot, c, 1'b0);
        jsu_pkg::MODE_LOWHEX: hex_char(eot, c, 1'b1);
        jsu_pkg::MODE_HIGH1: begin
          if (!eot && c == jsu_pkg::CH_BSLASH) begin
            mode = jsu_pkg::MODE_HIGH2;
          end else begin
            push_code_point({5'b0, high_pending});
            mode = jsu_pkg::MODE_STR;
            string_char(eot, c);
          end
        end
        jsu_pkg::MODE_HIGH2: begin
          if (!eot && c == jsu_pkg::CH_LOW_U) begin
            start_hex(jsu_pkg::MODE_LOWHEX);
          end else begin
            push_code_point({5'b0, high_pending});
            mode = jsu_pkg::MODE_STR;
            if (!room()) push_status(jsu_pkg::ST_UNTERMINATED);
            else escape_char(eot, c);
          end
        end
        default: mode = jsu_pkg::MODE_IDLE;
      endcase
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) due.push_back(step_out[i]);
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    task report(string what);
      if (errors < 100) $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [7:0] b, logic isd, logic [3:0] st, logic lst);
      decoded_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected result, byte %02h status %0d", b, st));
        return;
      end
      want = due.pop_front();
      if (b !== want.octet) report($sformatf("byte %02h, wanted %02h", b, want.octet));
      if (isd !== want.is_data) report($sformatf("data flag %b, wanted %b", isd, want.is_data));
      if (st !== want.st) report($sformatf("status %0d, wanted %s", st, want.st.name()));
      if (lst !== want.last) report($sformatf("last %b, wanted %b", lst, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [jsu_pkg::CAP_W-1:0] cfg_wdata;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [4:0] m_axis_tuser;
  logic m_axis_tlast;

  utf8_scoreboard sb;
  int live_items;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  bit hold_req;
  bit restart_next;

  json_string_unescape_utf8 #(
    .COUNT_WIDTH(16)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops ready at random, or for a long stretch on request.
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
        live_items++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[4:1], m_axis_tlast);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // The restart flag rides on the first transaction after it is requested.
  task automatic put_byte(input logic [7:0] b, input bit eot);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= {restart_next, eot};
    restart_next = 1'b0;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [jsu_pkg::CAP_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.capacity = v;
  endtask

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 4'd10) return jsu_pkg::CH_ZERO + {4'h0, n};
    return ($urandom_range(1) ? jsu_pkg::CH_LOW_A : jsu_pkg::CH_UP_A) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] c;
    logic [3:0] d;
    c = 8'($urandom_range(255));
    while (utf8_scoreboard::nibble_of(c, d)) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [7:0] bad_escape();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                     jsu_pkg::CH_LOW_B, jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N,
                     jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T, jsu_pkg::CH_LOW_U});
    return c;
  endfunction

  function automatic logic [7:0] esc_letter();
    case ($urandom_range(7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_LOW_B;
      4: return jsu_pkg::CH_LOW_F;
      5: return jsu_pkg::CH_LOW_N;
      6: return jsu_pkg::CH_LOW_R;
      default: return jsu_pkg::CH_LOW_T;
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(3))
      0: return jsu_pkg::CH_SPACE;
      1: return jsu_pkg::CH_TAB;
      2: return jsu_pkg::CH_LF;
      default: return jsu_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [15:0] bmp_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hD7FF));
      default: return 16'($urandom_range(16'hDC00, 16'hFFFF));
    endcase
  endfunction

  // Picks a surrogate of the given half, with its two range ends favored.
  function automatic logic [15:0] surrogate(input logic [15:0] base);
    case ($urandom_range(3))
      0: return base;
      1: return base + 16'h3FF;
      default: return base + 16'($urandom_range(16'h3FF));
    endcase
  endfunction

  // A digit position at or past ndig means no bad digit.
  task automatic put_hex(input logic [15:0] v, input int ndig, input int bad_at);
    for (int i = 0; i < ndig; i++) begin
      put_byte((i == bad_at) ? bad_digit() : digit_char(v[15 - 4 * i -: 4]), 1'b0);
    end
  endtask

  task automatic put_unicode(input logic [15:0] v);
    put_byte(jsu_pkg::CH_BSLASH, 1'b0);
    put_byte(jsu_pkg::CH_LOW_U, 1'b0);
    put_hex(v, 4, 4);
  endtask

  task automatic random_token();
    int elems;
    int pick;
    restart_next = ($urandom_range(99) < 92);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) put_byte(blank_byte(), 1'b0);
    pick = $urandom_range(99);
    if (pick < 4) begin
      put_byte(8'($urandom_range(255)), 1'b1);
      return;
    end
    if (pick < 9) begin
      put_byte(plain_byte(), 1'b0);
      return;
    end
    put_byte(jsu_pkg::CH_QUOTE, 1'b0);
    elems = $urandom_range(7);
    for (int i = 0; i < elems; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: put_byte(plain_byte(), 1'b0);
        4: begin
          put_byte(jsu_pkg::CH_BSLASH, 1'b0);
          put_byte(esc_letter(), 1'b0);
        end
        5, 6: put_unicode(bmp_value());
        7: begin
          put_unicode(surrogate(jsu_pkg::HIGH_SURR_MIN));
          put_unicode(surrogate(jsu_pkg::LOW_SURR_MIN));
        end
        default: begin
          put_unicode(surrogate(jsu_pkg::HIGH_SURR_MIN));
          case ($urandom_range(2))
            1: put_unicode(bmp_value());
            2: begin
              put_byte(jsu_pkg::CH_BSLASH, 1'b0);
              put_byte(esc_letter(), 1'b0);
            end
            default: ;
          endcase
        end
      endcase
    end
    case ($urandom_range(19))
      0: put_byte(8'($urandom_range(255)), 1'b1);
      1: begin
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(bad_escape(), 1'b0);
      end
      2: begin
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(8'($urandom_range(255)), 1'b1);
      end
      3: begin
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(jsu_pkg::CH_LOW_U, 1'b0);
        put_hex(bmp_value(), 4, $urandom_range(3));
      end
      4: begin
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(jsu_pkg::CH_LOW_U, 1'b0);
        put_hex(bmp_value(), $urandom_range(3), $urandom_range(4));
        put_byte(8'($urandom_range(255)), 1'b1);
      end
      5: begin
        put_unicode(surrogate(jsu_pkg::HIGH_SURR_MIN));
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(jsu_pkg::CH_LOW_U, 1'b0);
        put_hex(surrogate(jsu_pkg::LOW_SURR_MIN), 4, $urandom_range(3));
      end
      6: begin
        put_unicode(surrogate(jsu_pkg::HIGH_SURR_MIN));
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(jsu_pkg::CH_LOW_U, 1'b0);
        put_hex(surrogate(jsu_pkg::LOW_SURR_MIN), $urandom_range(3), $urandom_range(4));
        put_byte(8'($urandom_range(255)), 1'b1);
      end
      7: begin
        put_unicode(surrogate(jsu_pkg::HIGH_SURR_MIN));
        put_byte(8'($urandom_range(255)), 1'b1);
      end
      8: begin
        // Left in the middle of a hex escape; the next token usually restarts.
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        put_byte(jsu_pkg::CH_LOW_U, 1'b0);
        put_hex(bmp_value(), $urandom_range(3), 4);
        return;
      end
      9: begin
        put_byte(jsu_pkg::CH_BSLASH, 1'b0);
        return;
      end
      default: put_byte(jsu_pkg::CH_QUOTE, 1'b0);
    endcase
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [jsu_pkg::CAP_W-1:0] cap;
    int target;
    sb = new();
    live_items = 0;
    tx_idle_pct = 37;
    rx_idle_pct = 37;
    hold_req = 1'b0;
    restart_next = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Blank skip, extreme plain bytes, an escape and a surrogate pair.
    restart_next = 1'b1;
    put_byte(jsu_pkg::CH_TAB, 1'b0);
    put_byte(jsu_pkg::CH_QUOTE, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(jsu_pkg::CH_BSLASH, 1'b0);
    put_byte(jsu_pkg::CH_LOW_T, 1'b0);
    put_unicode(16'hD83D);
    put_unicode(16'hDE00);
    put_byte(jsu_pkg::CH_QUOTE, 1'b0);
    // Text ending before any quote, then a token that opens without one.
    restart_next = 1'b1;
    put_byte(8'hFF, 1'b1);
    restart_next = 1'b1;
    put_byte(jsu_pkg::CH_LOW_N, 1'b0);
    // A lone high surrogate followed by a plain byte, then the text ends.
    restart_next = 1'b1;
    put_byte(jsu_pkg::CH_QUOTE, 1'b0);
    put_unicode(jsu_pkg::HIGH_SURR_MAX);
    put_byte(jsu_pkg::CH_UP_A, 1'b0);
    put_byte(8'h00, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cap = 16'd5;
        1: cap = 16'd1;
        2: cap = 16'd12;
        3: cap = 16'hFFFF;
        4: cap = 16'd9;
        5: cap = 16'd30;
        default: cap = 16'($urandom_range(2, 20));
      endcase
      write_capacity(cap);
      tx_idle_pct = (p == 3) ? 0 : 37;
      rx_idle_pct = (p == 3) ? 0 : 37;
      if (p == 2) hold_req = 1'b1;
      target = live_items + PHASE_ITEMS;
      while (live_items < target) random_token();
    end

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: json_string_unescape_utf8.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_step.sv
rtl/jsu_outbuf.sv
rtl/json_string_unescape_utf8.sv
tb/sv/tb_top.sv
